// ----- rtl/core/ersc_pkg.sv -----
// Package with shared types, constants and the sine table for the vertex transform.
package ersc_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
  localparam int QUARTER         = 1 << QTR_BITS;
  localparam int CW              = 36;   // internal coordinate width
  localparam int PW              = CW + 16;
  localparam int DEPTH           = 9;    // pipeline stages from input to output

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] TRIG_ONE    = 16'd16384;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } out_item_t;

  // Sine and cosine in signed Q2.14.
  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } trig_t;

  typedef struct packed {
    trig_t rot_x;
    trig_t rot_y;
    trig_t rot_z;
  } trig_set_t;

  // Data that travels along the pipeline next to the arithmetic units.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    trig_set_t            trig;
    logic signed [15:0]   scale_x;
    logic signed [15:0]   scale_y;
    logic signed [15:0]   scale_z;
    logic signed [31:0]   offset_x;
    logic signed [31:0]   offset_y;
    logic signed [31:0]   offset_z;
  } side_t;

  typedef logic [14:0] sine_tab_t [QUARTER];

  // Quarter-wave sine entry, evaluated only at elaboration.
  function automatic logic [14:0] quarter_sine(input logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (k * HALF_PI_Q30) >> QTR_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    sum = $signed(($unsigned(sum) + 64'd32768) >> 16);
    if (sum > $signed({48'd0, TRIG_ONE})) begin
      sum = $signed({48'd0, TRIG_ONE});
    end
    return sum[14:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int k = 0; k < QUARTER; k++) begin
      t[k] = quarter_sine(64'(k));
    end
    return t;
  endfunction

  localparam sine_tab_t   SINE_TAB = build_sine_tab();
  localparam logic [14:0] SINE_TOP = quarter_sine(64'(QUARTER));

endpackage

// ----- rtl/core/ersc_trig.sv -----
// Registered sine and cosine lookup for the three rotation angles.
module ersc_trig (
  input  logic                      clk,
  input  logic                      en,
  input  logic [15:0]               angle_x,
  input  logic [15:0]               angle_y,
  input  logic [15:0]               angle_z,
  output ersc_pkg::trig_set_t       trig
);

  ersc_pkg::trig_set_t trig_r;
  ersc_pkg::trig_set_t trig_nxt;

  // Sine of a full-turn index built from the quarter-wave table.
  function automatic logic signed [15:0] sine_of(
    input logic [ersc_pkg::SINE_TABLE_BITS-1:0] idx
  );
    logic [1:0]                    quad;
    logic [ersc_pkg::QTR_BITS-1:0] r;
    logic [ersc_pkg::QTR_BITS:0]   k;
    logic [14:0]                   mag;
    quad = idx[ersc_pkg::SINE_TABLE_BITS-1 -: 2];
    r    = idx[ersc_pkg::QTR_BITS-1:0];
    if (quad[0]) begin
      k = (ersc_pkg::QTR_BITS+1)'(ersc_pkg::QUARTER) - {1'b0, r};
    end else begin
      k = {1'b0, r};
    end
    if (k[ersc_pkg::QTR_BITS]) begin
      mag = ersc_pkg::SINE_TOP;
    end else begin
      mag = ersc_pkg::SINE_TAB[k[ersc_pkg::QTR_BITS-1:0]];
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic ersc_pkg::trig_t trig_of(input logic [15:0] angle);
    logic [ersc_pkg::SINE_TABLE_BITS-1:0] idx;
    ersc_pkg::trig_t                      t;
    idx     = angle[15 -: ersc_pkg::SINE_TABLE_BITS];
    t.sin_v = sine_of(idx);
    t.cos_v = sine_of(idx + ersc_pkg::SINE_TABLE_BITS'(ersc_pkg::QUARTER));
    return t;
  endfunction

  always_comb begin
    trig_nxt.rot_x = trig_of(angle_x);
    trig_nxt.rot_y = trig_of(angle_y);
    trig_nxt.rot_z = trig_of(angle_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

// ----- rtl/core/ersc_rot.sv -----
// Two-stage plane rotation: (u, v) -> (u*c - v*s, u*s + v*c), rounded from Q2.14.
module ersc_rot (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ersc_pkg::CW-1:0]    u,
  input  logic signed [ersc_pkg::CW-1:0]    v,
  input  ersc_pkg::trig_t                   trig,
  output logic signed [ersc_pkg::CW-1:0]    nu,
  output logic signed [ersc_pkg::CW-1:0]    nv
);

  logic signed [ersc_pkg::PW-1:0] uc_r, vs_r, us_r, vc_r;
  logic signed [ersc_pkg::PW:0]   sum_u, sum_v;
  logic signed [ersc_pkg::PW:0]   rnd_u, rnd_v;
  logic signed [ersc_pkg::CW-1:0] nu_r, nv_r, nu_nxt, nv_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      uc_r <= u * trig.cos_v;
      vs_r <= v * trig.sin_v;
      us_r <= u * trig.sin_v;
      vc_r <= v * trig.cos_v;
    end
  end

  // Rotated values stay within 35 bits, so the top bits of the shift are sign copies.
  always_comb begin
    sum_u  = (ersc_pkg::PW+1)'(uc_r) - (ersc_pkg::PW+1)'(vs_r);
    sum_v  = (ersc_pkg::PW+1)'(us_r) + (ersc_pkg::PW+1)'(vc_r);
    rnd_u  = (sum_u + (ersc_pkg::PW+1)'(1 << 13)) >>> 14;
    rnd_v  = (sum_v + (ersc_pkg::PW+1)'(1 << 13)) >>> 14;
    nu_nxt = rnd_u[ersc_pkg::CW-1:0];
    nv_nxt = rnd_v[ersc_pkg::CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nu_r <= nu_nxt;
      nv_r <= nv_nxt;
    end
  end

  assign nu = nu_r;
  assign nv = nv_r;

endmodule

// ----- rtl/core/ersc_scale.sv -----
// Two-stage per-axis scale, translation and saturation to signed Q16.16.
module ersc_scale (
  input  logic                 clk,
  input  logic                 en,
  input  ersc_pkg::side_t      data,
  output ersc_pkg::out_item_t  result
);

  localparam int SW = ersc_pkg::PW + 1;

  logic signed [ersc_pkg::PW-1:0] px_r, py_r, pz_r;
  logic signed [31:0]             ox_r, oy_r, oz_r;
  ersc_pkg::out_item_t            result_r, result_nxt;
  logic                           sat_x, sat_y, sat_z;

  function automatic logic signed [31:0] fit(
    input logic signed [ersc_pkg::PW-1:0] p,
    input logic signed [31:0]             off,
    output logic                          sat
  );
    logic signed [SW-1:0] s;
    s   = ((SW)'(p) + (SW)'(1 << 7)) >>> 8;
    s   = s + (SW)'(off);
    sat = 1'b0;
    if (s > (SW)'(32'sh7fffffff)) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end else if (s < -(SW)'(33'sh080000000)) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= data.x * data.scale_x;
      py_r <= data.y * data.scale_y;
      pz_r <= data.z * data.scale_z;
      ox_r <= data.offset_x;
      oy_r <= data.offset_y;
      oz_r <= data.offset_z;
    end
  end

  always_comb begin
    result_nxt.out_x     = fit(px_r, ox_r, sat_x);
    result_nxt.out_y     = fit(py_r, oy_r, sat_y);
    result_nxt.out_z     = fit(pz_r, oz_r, sat_z);
    result_nxt.saturated = sat_x | sat_y | sat_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// ----- rtl/core/euler_rotate_scale_translate.sv -----
// Top level of the vertex rotate, scale and translate pipeline.
//
//   channel | ports                           | direction | payload
//   --------+---------------------------------+-----------+---------------------
//   input   | in_valid, in_stall, in_data     | in        | ersc_pkg::in_item_t
//   result  | out_valid, out_stall, out_data  | out       | ersc_pkg::out_item_t
//
// The pipeline takes one transaction per cycle unless a finished result is held back by out_stall.
// The stages are the trig lookup, then a multiply stage and a rounding stage for each of
// the Y, X and Z rotations, then a multiply stage and a translate-and-clamp stage.
// Reset (rst_n low at a clock edge) empties the pipeline; no clearing pass is needed.
// A stall on the result side while a result waits at the output freezes every stage
// together, so nothing is lost or repeated, and in_stall rises in the same cycle.
module euler_rotate_scale_translate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ersc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ersc_pkg::out_item_t  out_data
);

  // One valid bit per stage; the last one marks the output register as full.
  logic [ersc_pkg::DEPTH-1:0] valid_r, valid_nxt;
  // Carried data alongside the arithmetic, one tap per stage up to the scale unit.
  ersc_pkg::side_t side_r [7];
  ersc_pkg::side_t m0, m2, m4, m6;
  ersc_pkg::trig_set_t trig;
  logic signed [ersc_pkg::CW-1:0] y_nu, y_nv, x_nu, x_nv, z_nu, z_nv;
  logic adv;

  // The whole pipeline moves unless a finished result is being held back.
  assign adv      = !(valid_r[ersc_pkg::DEPTH-1] && out_stall);
  assign in_stall = !adv;

  assign valid_nxt = {valid_r[ersc_pkg::DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  // Input stage: sign-extend the coordinates into the wider internal format.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].x        <= ersc_pkg::CW'(in_data.pos_x);
      side_r[0].y        <= ersc_pkg::CW'(in_data.pos_y);
      side_r[0].z        <= ersc_pkg::CW'(in_data.pos_z);
      side_r[0].trig     <= '0;
      side_r[0].scale_x  <= in_data.scale_x;
      side_r[0].scale_y  <= in_data.scale_y;
      side_r[0].scale_z  <= in_data.scale_z;
      side_r[0].offset_x <= in_data.offset_x;
      side_r[0].offset_y <= in_data.offset_y;
      side_r[0].offset_z <= in_data.offset_z;
    end
  end

  ersc_trig u_trig (
    .clk     (clk),
    .en      (adv),
    .angle_x (in_data.angle_x),
    .angle_y (in_data.angle_y),
    .angle_z (in_data.angle_z),
    .trig    (trig)
  );

  // m0 adds the trig values; m2, m4 and m6 replace the coordinates just rotated.
  always_comb begin
    m0      = side_r[0];
    m0.trig = trig;
    m2      = side_r[2];
    m2.z    = y_nu;
    m2.x    = y_nv;
    m4      = side_r[4];
    m4.y    = x_nu;
    m4.z    = x_nv;
    m6      = side_r[6];
    m6.x    = z_nu;
    m6.y    = z_nv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= m0;
      side_r[2] <= side_r[1];
      side_r[3] <= m2;
      side_r[4] <= side_r[3];
      side_r[5] <= m4;
      side_r[6] <= side_r[5];
    end
  end

  // Rotation about Y: (z, x) -> (z*c - x*s, z*s + x*c).
  ersc_rot u_rot_y (
    .clk  (clk),
    .en   (adv),
    .u    (m0.z),
    .v    (m0.x),
    .trig (m0.trig.rot_y),
    .nu   (y_nu),
    .nv   (y_nv)
  );

  // Rotation about X: (y, z) -> (y*c - z*s, y*s + z*c).
  ersc_rot u_rot_x (
    .clk  (clk),
    .en   (adv),
    .u    (m2.y),
    .v    (m2.z),
    .trig (m2.trig.rot_x),
    .nu   (x_nu),
    .nv   (x_nv)
  );

  // Rotation about Z; both outputs use the y from before this rotation.
  ersc_rot u_rot_z (
    .clk  (clk),
    .en   (adv),
    .u    (m4.x),
    .v    (m4.y),
    .trig (m4.trig.rot_z),
    .nu   (z_nu),
    .nv   (z_nv)
  );

  ersc_scale u_scale (
    .clk    (clk),
    .en     (adv),
    .data   (m6),
    .result (out_data)
  );

  assign out_valid = valid_r[ersc_pkg::DEPTH-1];

  // A held result must still be there in the next cycle.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("held result dropped");

  // An accepted transaction always occupies the first stage afterwards.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_r[0])
    else $error("accepted transaction lost at pipeline entry");

  // While stalled, no stage may move.
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(valid_r))
    else $error("pipeline moved during stall");

endmodule

// ----- tb/sv/euler_rotate_scale_translate_test.sv -----
// Self-checking testbench for the vertex rotate, scale and translate pipeline.
module euler_rotate_scale_translate_test;

  localparam int PERIOD_HALF = 6;
  localparam int STB = ersc_pkg::SINE_TABLE_BITS;
  localparam int CYCLE_LIMIT = 200000;

  // Predicts transformed vertices and keeps them in arrival order until the
  // block returns its results.
  class vertex_scoreboard;
    ersc_pkg::out_item_t pending_vertices[$];
    int                  error_count;

    // Quarter-wave sine in Q2.14, computed with the same truncating series.
    function longint quarter_wave(longint unsigned k);
      longint unsigned ang, ang2, term;
      longint acc;
      ang  = (k * 64'd1686629713) >> (STB - 2);
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = longint'(ang);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc -= longint'(term);
        end else begin
          acc += longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = longint'((unsigned'(acc) + 64'd32768) >> 16);
      if (acc > 16384) begin
        acc = 16384;
      end
      return acc;
    endfunction

    function longint wave_at(longint unsigned idx);
      longint unsigned i, quad, r;
      longint s;
      i    = idx & ((1 << STB) - 1);
      quad = i >> (STB - 2);
      r    = i & ((1 << (STB - 2)) - 1);
      s    = quad[0] ? quarter_wave((1 << (STB - 2)) - r) : quarter_wave(r);
      return quad[1] ? -s : s;
    endfunction

    // Rounds half up with a floor division by 2^sh.
    function longint round_down_half(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function void sin_cos(logic [15:0] angle, output longint s, output longint c);
      longint unsigned idx;
      idx = angle >> (16 - STB);
      s = wave_at(idx);
      c = wave_at(idx + (1 << (STB - 2)));
    endfunction

    function longint scale_offset(longint v, logic signed [15:0] sc,
                                  logic signed [31:0] off, ref bit clamped);
      longint r;
      r = round_down_half(v * longint'(sc), 8) + longint'(off);
      if (r > 64'sd2147483647) begin
        clamped = 1;
        r = 64'sd2147483647;
      end
      if (r < -64'sd2147483648) begin
        clamped = 1;
        r = -64'sd2147483648;
      end
      return r;
    endfunction

    function void note_vertex(ersc_pkg::in_item_t v);
      longint x, y, z, s, c, nx, ny, nz;
      bit clamped;
      ersc_pkg::out_item_t e;
      clamped = 0;
      x = longint'(v.pos_x);
      y = longint'(v.pos_y);
      z = longint'(v.pos_z);
      sin_cos(v.angle_y, s, c);
      nx = round_down_half(x * c + z * s, 14);
      nz = round_down_half(z * c - x * s, 14);
      x = nx;
      z = nz;
      sin_cos(v.angle_x, s, c);
      ny = round_down_half(y * c - z * s, 14);
      nz = round_down_half(y * s + z * c, 14);
      y = ny;
      z = nz;
      // The Z rotation uses the y from before this rotation for both terms.
      sin_cos(v.angle_z, s, c);
      nx = round_down_half(x * c - y * s, 14);
      ny = round_down_half(x * s + y * c, 14);
      e.out_x = 32'(scale_offset(nx, v.scale_x, v.offset_x, clamped));
      e.out_y = 32'(scale_offset(ny, v.scale_y, v.offset_y, clamped));
      e.out_z = 32'(scale_offset(z, v.scale_z, v.offset_z, clamped));
      e.saturated = clamped;
      pending_vertices.push_back(e);
    endfunction

    task check_vertex(ersc_pkg::out_item_t got);
      ersc_pkg::out_item_t e;
      if (pending_vertices.size() == 0) begin
        report_mismatch("result arrived with no transaction pending");
        return;
      end
      e = pending_vertices.pop_front();
      if (got.out_x !== e.out_x) report_mismatch($sformatf("out_x %h exp %h", got.out_x, e.out_x));
      if (got.out_y !== e.out_y) report_mismatch($sformatf("out_y %h exp %h", got.out_y, e.out_y));
      if (got.out_z !== e.out_z) report_mismatch($sformatf("out_z %h exp %h", got.out_z, e.out_z));
      if (got.saturated !== e.saturated) begin
        report_mismatch($sformatf("saturated %b exp %b", got.saturated, e.saturated));
      end
    endtask

    task report_mismatch(string what);
      error_count++;
      $display("MISMATCH: %s", what);
    endtask
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_stall;
  ersc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 0;
  ersc_pkg::out_item_t out_data;

  vertex_scoreboard board = new();
  int  cycle_count = 0;
  bit  stimulus_done = 0;
  int  stall_mode = 0;

  euler_rotate_scale_translate dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #PERIOD_HALF clk = ~clk;

  // Accepted transactions are sampled at the edge, before the nonblocking
  // updates of this step land, so ordering within the step does not matter.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && !in_stall) board.note_vertex(in_data);
    if (rst_n && out_valid && !out_stall) board.check_vertex(out_data);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver stalls on its own pattern: phases of none, light and heavy
  // back-pressure, each phase picked at random.
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 24)) :
                                       -32'($urandom_range(0, 1 << 24));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ersc_pkg::in_item_t random_vertex();
    ersc_pkg::in_item_t v;
    v.pos_x = pick_coord();
    v.pos_y = pick_coord();
    v.pos_z = pick_coord();
    v.angle_x = 16'($urandom);
    v.angle_y = 16'($urandom);
    v.angle_z = 16'($urandom);
    v.scale_x = pick_scale();
    v.scale_y = pick_scale();
    v.scale_z = pick_scale();
    v.offset_x = pick_coord();
    v.offset_y = pick_coord();
    v.offset_z = pick_coord();
    return v;
  endfunction

  // Presents one transaction and holds it until the block takes it.
  task automatic send_vertex(ersc_pkg::in_item_t v);
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_directed();
    ersc_pkg::in_item_t v;
    logic [15:0] angles[8];
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h003F,
               16'h0040, 16'h2000};
    // Quadrant boundaries and sub-step angle bits, which must be ignored.
    foreach (angles[i]) begin
      v = '0;
      v.pos_x = 32'h0001_0000;
      v.pos_y = 32'h0002_0000;
      v.pos_z = -32'sh0003_0000;
      v.angle_x = angles[i];
      v.angle_y = angles[(i + 3) % 8];
      v.angle_z = angles[(i + 5) % 8];
      v.scale_x = 16'h0100;
      v.scale_y = 16'h0100;
      v.scale_z = 16'h0100;
      send_vertex(v);
    end
    // Full-scale coordinates, scales and offsets: the final clamp in both directions.
    for (int i = 0; i < 8; i++) begin
      v.pos_x = i[0] ? 32'h7FFFFFFF : 32'h80000000;
      v.pos_y = i[1] ? 32'h7FFFFFFF : 32'h80000000;
      v.pos_z = i[2] ? 32'h80000000 : 32'h7FFFFFFF;
      v.angle_x = 16'(16'h1000 * i);
      v.angle_y = 16'(16'hFFFF - 16'h1000 * i);
      v.angle_z = 16'(16'h2000 * i);
      v.scale_x = i[0] ? 16'h7FFF : 16'h8000;
      v.scale_y = i[1] ? 16'h8000 : 16'h7FFF;
      v.scale_z = i[2] ? 16'h7FFF : 16'h8000;
      v.offset_x = i[1] ? 32'h7FFFFFFF : 32'h80000000;
      v.offset_y = i[2] ? 32'h7FFFFFFF : 32'h80000000;
      v.offset_z = i[0] ? 32'h7FFFFFFF : 32'h80000000;
      send_vertex(v);
    end
    // Zero scale leaves only the offset.
    v = random_vertex();
    v.scale_x = '0;
    v.scale_y = '0;
    v.scale_z = '0;
    send_vertex(v);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    for (int sent = 0; sent < 750; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < 750; b++, sent++) begin
        send_vertex(random_vertex());
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    while (board.pending_vertices.size() != 0) @(posedge clk);
    repeat (ersc_pkg::DEPTH + 10) @(posedge clk);
    if (board.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
